>>> sv/scs_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// scs_pkg
// Shared types and constants of the signed count sketch.
// ---------------------------------------------------------------------------
package scs_pkg;

   localparam int KEY_W        = 64;
   localparam int CNT_W        = 64;
   localparam int ROWS_REG_W   = 4;
   localparam int WIDTH_REG_W  = 13;
   localparam int CSR_DATA_W   = 13;
   localparam int CSR_INDEX_W  = 1;
   localparam int MOD_BITS     = 4;
   localparam int MOD_STEPS    = KEY_W / MOD_BITS;
   localparam int STEP_W       = $clog2(MOD_STEPS);
   localparam logic [31:0] SIGN_SALT = 32'h9e3779b9;

   localparam logic [ROWS_REG_W-1:0]  ROWS_RESET  = 4'd5;
   localparam logic [WIDTH_REG_W-1:0] WIDTH_RESET = 13'd4096;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_ROWS  = 1'b0,
      REG_WIDTH = 1'b1
   } reg_index_type;

   typedef enum logic [0:0] {
      OP_INSERT   = 1'b0,
      OP_ESTIMATE = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOAD,
      ST_MOD,
      ST_READ,
      ST_UPDATE,
      ST_RANK,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic load_item;
      logic mod_load;
      logic mod_step;
      logic mem_rd;
      logic update;
      logic clear_wr;
      logic latch_zero;
      logic latch_result;
   } dp_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic is_estimate;
      logic rank_hit;
   } dp_status_type;

endpackage
`default_nettype wire

>>> sv/scs_datapath.sv
`default_nettype none
// ---------------------------------------------------------------------------
// scs_datapath
// Hash mixing, radix-16 modulo unit, counter memory and median ranking.
// ---------------------------------------------------------------------------
module scs_datapath #(
   parameter int MAX_ROWS    = 8,
   parameter int MAX_COLUMNS = 4096,
   parameter int RW          = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
   parameter int RCW         = $clog2(MAX_ROWS + 1),
   parameter int WW          = $clog2(MAX_COLUMNS + 1)
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire scs_pkg::dp_cmd_type     cmd,
   output scs_pkg::dp_status_type       status,
   input  wire  [RW-1:0]                row,
   input  wire  [RW-1:0]                cand,
   input  wire  [RCW-1:0]               rows_eff,
   input  wire  [WW-1:0]                width_eff,
   input  wire                          in_cmd,
   input  wire  [scs_pkg::KEY_W-1:0]    in_key,
   input  wire  [scs_pkg::CNT_W-1:0]    in_amount,
   output logic [scs_pkg::CNT_W-1:0]    out_count,
   output logic                         out_is_estimate
);

   localparam int DEPTH = MAX_ROWS * MAX_COLUMNS;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(MAX_COLUMNS);

   logic [scs_pkg::CNT_W-1:0] mem [DEPTH];
   logic [scs_pkg::CNT_W-1:0] rd_data_ff;
   logic [AW-1:0]             clr_ff;

   logic                      op_ff;
   logic [scs_pkg::KEY_W-1:0] key_ff;
   logic [scs_pkg::CNT_W-1:0] amount_ff;
   logic [scs_pkg::KEY_W-1:0] div_ff, div_in;
   logic [WW-1:0]             rem_ff, rem_in;
   logic [scs_pkg::CNT_W-1:0] vals_ff [MAX_ROWS];
   logic [scs_pkg::CNT_W-1:0] res_ff;

   logic [scs_pkg::KEY_W-1:0] h1, h2, h3;
   logic                      neg;
   logic [AW-1:0]             addr;
   logic [scs_pkg::CNT_W-1:0] signed_amount, signed_rd, cand_val;
   logic [MAX_ROWS-1:0]       below;
   logic [RCW-1:0]            rank;

   // per-row mix of the key hash
   always_comb begin
      h1 = key_ff ^ (key_ff << 13) ^ scs_pkg::KEY_W'(row);
      h2 = h1 ^ (h1 >> 7);
      h3 = h2 ^ (h2 << 17);
   end

   // bit 0 of row*salt is row[0] & salt[0]
   assign neg = key_ff[0] ^ key_ff[11] ^ (row[0] & scs_pkg::SIGN_SALT[0]);

   assign addr = AW'(32'(row) * MAX_COLUMNS + 32'(rem_ff[CW-1:0]));

   assign signed_amount = neg ? (scs_pkg::CNT_W'(0) - amount_ff) : amount_ff;
   assign signed_rd     = neg ? (scs_pkg::CNT_W'(0) - rd_data_ff) : rd_data_ff;

   // restoring modulo, four dividend bits a step
   always_comb begin
      logic [WW:0] t;
      t      = '0;
      rem_in = rem_ff;
      div_in = div_ff;
      for (int k = 0; k < scs_pkg::MOD_BITS; k++) begin
         t = {rem_in, div_in[scs_pkg::KEY_W-1]};
         div_in = div_in << 1;
         if (t >= {1'b0, width_eff}) begin
            t = t - {1'b0, width_eff};
         end
         rem_in = t[WW-1:0];
      end
   end

   // stable rank of the candidate among the collected values
   assign cand_val = vals_ff[cand];
   always_comb begin
      for (int j = 0; j < MAX_ROWS; j++) begin
         below[j] = (RCW'(j) < rows_eff) &&
                    (($signed(vals_ff[j]) < $signed(cand_val)) ||
                     ((vals_ff[j] == cand_val) && (RW'(j) < cand)));
      end
      rank = RCW'($countones(below));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear_wr) begin
         clr_ff <= clr_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clear_wr) begin
         mem[clr_ff] <= '0;
      end else if (cmd.update && (op_ff == scs_pkg::OP_INSERT)) begin
         mem[addr] <= rd_data_ff + signed_amount;
      end
      if (cmd.mem_rd) begin
         rd_data_ff <= mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         op_ff     <= in_cmd;
         key_ff    <= in_key;
         amount_ff <= in_amount;
      end
      if (cmd.mod_load) begin
         div_ff <= h3;
         rem_ff <= '0;
      end else if (cmd.mod_step) begin
         div_ff <= div_in;
         rem_ff <= rem_in;
      end
      if (cmd.update && (op_ff == scs_pkg::OP_ESTIMATE)) begin
         vals_ff[row] <= signed_rd;
      end
      if (cmd.latch_zero) begin
         res_ff <= '0;
      end else if (cmd.latch_result) begin
         res_ff <= cand_val;
      end
   end

   assign status.clear_last  = (32'(clr_ff) == DEPTH - 1);
   assign status.is_estimate = (op_ff == scs_pkg::OP_ESTIMATE);
   assign status.rank_hit    = (rank == (rows_eff >> 1));

   assign out_count       = res_ff;
   assign out_is_estimate = op_ff;

endmodule
`default_nettype wire

>>> sv/scs_controller.sv
`default_nettype none
// ---------------------------------------------------------------------------
// scs_controller
// Sequencer: memory clear, per-row modulo and update, median search.
// ---------------------------------------------------------------------------
module scs_controller #(
   parameter int MAX_ROWS = 8,
   parameter int RW       = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
   parameter int RCW      = $clog2(MAX_ROWS + 1)
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_fire,
   output logic                         req_ready,
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   input  wire  [RCW-1:0]               rows_eff,
   output scs_pkg::dp_cmd_type          cmd,
   input  wire scs_pkg::dp_status_type  status,
   output logic [RW-1:0]                row,
   output logic [RW-1:0]                cand
);

   scs_pkg::state_type          state_ff, state_in;
   logic [scs_pkg::STEP_W-1:0]  step_ff, step_in;
   logic [RW-1:0]               row_ff, row_in;
   logic [RW-1:0]               cand_ff, cand_in;
   logic                        last_row;

   assign last_row = (RCW'(row_ff) + RCW'(1)) == rows_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= scs_pkg::ST_CLEAR;
         step_ff  <= '0;
         row_ff   <= '0;
         cand_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         row_ff   <= row_in;
         cand_ff  <= cand_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      row_in    = row_ff;
      cand_in   = cand_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         scs_pkg::ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (status.clear_last) begin
               state_in = scs_pkg::ST_IDLE;
            end
         end
         scs_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_fire) begin
               cmd.load_item = 1'b1;
               row_in        = '0;
               state_in      = scs_pkg::ST_LOAD;
            end
         end
         scs_pkg::ST_LOAD: begin
            cmd.mod_load = 1'b1;
            step_in      = '0;
            state_in     = scs_pkg::ST_MOD;
         end
         scs_pkg::ST_MOD: begin
            cmd.mod_step = 1'b1;
            step_in      = step_ff + scs_pkg::STEP_W'(1);
            if (step_ff == scs_pkg::STEP_W'(scs_pkg::MOD_STEPS - 1)) begin
               state_in = scs_pkg::ST_READ;
            end
         end
         scs_pkg::ST_READ: begin
            cmd.mem_rd = 1'b1;
            state_in   = scs_pkg::ST_UPDATE;
         end
         scs_pkg::ST_UPDATE: begin
            cmd.update = 1'b1;
            if (!last_row) begin
               row_in   = row_ff + RW'(1);
               state_in = scs_pkg::ST_LOAD;
            end else if (status.is_estimate) begin
               cand_in  = '0;
               state_in = scs_pkg::ST_RANK;
            end else begin
               cmd.latch_zero = 1'b1;
               state_in       = scs_pkg::ST_RESP;
            end
         end
         scs_pkg::ST_RANK: begin
            if (status.rank_hit) begin
               cmd.latch_result = 1'b1;
               state_in         = scs_pkg::ST_RESP;
            end else begin
               cand_in = cand_ff + RW'(1);
            end
         end
         scs_pkg::ST_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = scs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = scs_pkg::ST_IDLE;
         end
      endcase
   end

   assign row  = row_ff;
   assign cand = cand_ff;

endmodule
`default_nettype wire

>>> sv/signed_count_sketch.sv
`default_nettype none
// ---------------------------------------------------------------------------
// signed_count_sketch
// Count sketch over signed 64-bit counters: insert and median estimate.
// ---------------------------------------------------------------------------
// A request on req_ carries a key hash and an amount; req_tuser selects
// insert (0) or estimate (1). Every request gives one response on rsp_:
// the upper median of the signed row counters for an estimate, zero for
// an insert, with rsp_tuser telling which. One request is in flight at a
// time; req_tready is low from acceptance until the response is taken.
// Each row goes through a mix load, the radix-16 modulo unit that forms
// the column, a memory read and a read-modify-write. For an estimate a
// median search follows the last row, one candidate rank per cycle.
// At reset the counter memory is cleared one entry per cycle, through all
// MAX_ROWS*MAX_COLUMNS entries (32768 by default); no request is accepted
// meanwhile, while csr_ writes are taken. A stalled response holds in its
// output register until rsp_tready rises. The user must make csr_ writes
// only while idle; the block itself does not enforce it.
// ---------------------------------------------------------------------------
module signed_count_sketch #(
   parameter int MAX_ROWS    = 8,
   parameter int MAX_COLUMNS = 4096
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_tvalid,
   output logic                               req_tready,
   input  wire  [2*scs_pkg::KEY_W-1:0]        req_tdata,   // key_hash, amount
   input  wire                                req_tuser,   // cmd
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready,
   output logic [scs_pkg::CNT_W-1:0]          rsp_tdata,   // count_estimate
   output logic                               rsp_tuser,   // was_estimate
   input  wire                                csr_valid,
   output logic                               csr_ready,
   input  wire  [scs_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire  [scs_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int RCW = $clog2(MAX_ROWS + 1);
   localparam int WW  = $clog2(MAX_COLUMNS + 1);

   logic [scs_pkg::ROWS_REG_W-1:0]  rows_ff;
   logic [scs_pkg::WIDTH_REG_W-1:0] width_ff;
   logic [RCW-1:0]                  rows_eff;
   logic [WW-1:0]                   width_eff;
   scs_pkg::dp_cmd_type             cmd;
   scs_pkg::dp_status_type          status;
   logic [RW-1:0]                   row, cand;
   logic                            req_fire;

   assign csr_ready = 1'b1;
   assign req_fire  = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff  <= scs_pkg::ROWS_RESET;
         width_ff <= scs_pkg::WIDTH_RESET;
      end else if (csr_valid) begin
         unique case (scs_pkg::reg_index_type'(csr_index))
            scs_pkg::REG_ROWS:  rows_ff  <= csr_data[scs_pkg::ROWS_REG_W-1:0];
            scs_pkg::REG_WIDTH: width_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // zero acts as one, too large saturates
   always_comb begin
      if (rows_ff == '0) begin
         rows_eff = RCW'(1);
      end else if (32'(rows_ff) > MAX_ROWS) begin
         rows_eff = RCW'(MAX_ROWS);
      end else begin
         rows_eff = RCW'(rows_ff);
      end
      if (width_ff == '0) begin
         width_eff = WW'(1);
      end else if (32'(width_ff) > MAX_COLUMNS) begin
         width_eff = WW'(MAX_COLUMNS);
      end else begin
         width_eff = WW'(width_ff);
      end
   end

   scs_controller #(
      .MAX_ROWS (MAX_ROWS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_fire),
      .req_ready (req_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rows_eff  (rows_eff),
      .cmd       (cmd),
      .status    (status),
      .row       (row),
      .cand      (cand)
   );

   scs_datapath #(
      .MAX_ROWS    (MAX_ROWS),
      .MAX_COLUMNS (MAX_COLUMNS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .row             (row),
      .cand            (cand),
      .rows_eff        (rows_eff),
      .width_eff       (width_eff),
      .in_cmd          (req_tuser),
      .in_key          (req_tdata[scs_pkg::KEY_W-1:0]),
      .in_amount       (req_tdata[2*scs_pkg::KEY_W-1:scs_pkg::KEY_W]),
      .out_count       (rsp_tdata),
      .out_is_estimate (rsp_tuser)
   );

`ifndef SYNTHESIS
   // one request at a time: never ready while a response is pending
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("request accepted while response pending");

   a_insert_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata == '0))
      else $error("insert response not zero");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (!req_tready && !rsp_tvalid))
      else $error("accepted request finished in one cycle");
`endif

endmodule
`default_nettype wire

>>> bench/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Bench for the signed count sketch. Directed and random inserts and
// estimates go through a queue-fed driver. A behavioral copy of the counter
// table predicts each response, and a monitor compares responses in order.
// ---------------------------------------------------------------------------
module tb_top;

   localparam int N_ROWS = 8;
   localparam int N_COLS = 4096;

   typedef struct packed {
      scs_pkg::op_type op;
      logic [63:0]     key;
      logic [63:0]     amount;
   } sketch_req_type;

   typedef struct packed {
      logic [63:0] estimate;
      logic        is_est;
   } sketch_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [127:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic rsp_tuser;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [scs_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [scs_pkg::CSR_DATA_W-1:0] csr_data = '0;

   signed_count_sketch uut (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser,
      .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   sketch_req_type pending_reqs[$];
   sketch_rsp_type expected_rsps[$];
   logic [63:0] sketch_table[N_ROWS*N_COLS];
   logic [3:0]  rows_reg = scs_pkg::ROWS_RESET;
   logic [12:0] width_reg = scs_pkg::WIDTH_RESET;
   int errors = 0;
   bit quiet = 0;             // no idling on either side
   logic stall_rsp = 1'b0;    // long receiver stall
   event hold_go;
   int req_gap = 0;
   int rsp_gap = 0;

   initial forever #1 clock = ~clock;

   // receiver hold-off, counted here in cycles
   initial forever begin
      @(hold_go);
      stall_rsp <= 1'b1;
      repeat (400) @(posedge clock);
      stall_rsp <= 1'b0;
   end

   function automatic logic [11:0] column_for(logic [63:0] key, int row, int width);
      logic [63:0] h;
      h = key;
      h = h ^ ((h << 13) ^ 64'(row));
      h = h ^ (h >> 7);
      h = h ^ (h << 17);
      return 12'(h % 64'(width));
   endfunction

   function automatic bit row_negated(logic [63:0] key, int row);
      logic [31:0] salt;
      salt = 32'(row) * scs_pkg::SIGN_SALT;
      return key[0] ^ key[11] ^ salt[0];
   endfunction

   function automatic sketch_rsp_type apply_request(sketch_req_type rq);
      int rows, width, j;
      logic [63:0] v, s;
      logic signed [63:0] vals[N_ROWS];
      logic signed [63:0] t;
      sketch_rsp_type r;
      rows = (rows_reg == 0) ? 1 : (rows_reg > N_ROWS) ? N_ROWS : rows_reg;
      width = (width_reg == 0) ? 1 : (width_reg > N_COLS) ? N_COLS : width_reg;
      for (int i = 0; i < rows; i++) begin
         j = i * N_COLS + column_for(rq.key, i, width);
         if (rq.op == scs_pkg::OP_INSERT) begin
            s = row_negated(rq.key, i) ? -rq.amount : rq.amount;
            sketch_table[j] = sketch_table[j] + s;
         end else begin
            v = sketch_table[j];
            vals[i] = row_negated(rq.key, i) ? -v : v;
         end
      end
      if (rq.op == scs_pkg::OP_INSERT) begin
         r.estimate = '0;
         r.is_est = 1'b0;
         return r;
      end
      for (int i = 1; i < rows; i++) begin
         t = vals[i];
         j = i;
         while (j > 0 && vals[j-1] > t) begin
            vals[j] = vals[j-1];
            j--;
         end
         vals[j] = t;
      end
      r.estimate = vals[rows/2];
      r.is_est = 1'b1;
      return r;
   endfunction

   // driver
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            expected_rsps = {expected_rsps, apply_request(pending_reqs.pop_front())};
         end
         if (req_gap > 0) begin
            req_gap <= req_gap - 1;
            req_tvalid <= 1'b0;
         end else if (req_tvalid && !req_tready) begin
            req_tvalid <= 1'b1;
         end else if (pending_reqs.size() > 0) begin
            if (!quiet && $urandom_range(0, 9) == 0) begin
               req_gap <= $urandom_range(1, 12) - 1;
               req_tvalid <= 1'b0;
            end else begin
               sketch_req_type nx;
               nx = pending_reqs[0];
               req_tvalid <= 1'b1;
               req_tdata <= {nx.amount, nx.key};
               req_tuser <= nx.op;
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected response %h/%b", $time, rsp_tdata, rsp_tuser);
               errors++;
            end else begin
               sketch_rsp_type e;
               e = expected_rsps.pop_front();
               if (e.estimate !== rsp_tdata) begin
                  $display("%0t: count_estimate expected %h actual %h", $time,
                           e.estimate, rsp_tdata);
                  errors++;
               end
               if (e.is_est !== rsp_tuser) begin
                  $display("%0t: was_estimate expected %b actual %b", $time,
                           e.is_est, rsp_tuser);
                  errors++;
               end
            end
         end
         if (stall_rsp) begin
            rsp_tready <= 1'b0;
         end else if (rsp_gap > 0) begin
            rsp_gap <= rsp_gap - 1;
            rsp_tready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            rsp_gap <= $urandom_range(1, 12) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic write_reg(scs_pkg::reg_index_type idx, logic [12:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == scs_pkg::REG_ROWS) rows_reg = value[3:0];
      else width_reg = value;
   endtask

   task automatic drain();
      while (pending_reqs.size() > 0 || req_tvalid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic add_req(scs_pkg::op_type op, logic [63:0] key, logic [63:0] amount);
      sketch_req_type rq;
      rq.op = op;
      rq.key = key;
      rq.amount = amount;
      pending_reqs = {pending_reqs, rq};
   endtask

   // keys drawn from a small pool so estimates hit inserted counters
   task automatic random_phase(int count, int pool);
      logic [63:0] keys[16];
      for (int i = 0; i < pool; i++) keys[i] = {$urandom, $urandom};
      for (int i = 0; i < count; i++) begin
         logic [63:0] k, a;
         k = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom}
                                         : keys[$urandom_range(0, pool - 1)];
         case ($urandom_range(0, 3))
            0: a = {$urandom, $urandom};
            1: a = 64'(signed'($urandom_range(0, 20)) - 10);
            2: a = {1'b1, 63'($urandom)};
            default: a = 64'($urandom_range(0, 1000));
         endcase
         add_req(scs_pkg::op_type'($urandom_range(0, 2) == 0), k, a);
      end
   endtask

   initial begin
      logic [3:0] row_set[6];
      logic [12:0] width_set[6];
      for (int i = 0; i < N_ROWS*N_COLS; i++) sketch_table[i] = '0;
      row_set = '{4'd5, 4'd1, 4'd0, 4'd8, 4'd15, 4'd4};
      width_set = '{13'd4096, 13'd1, 13'd0, 13'd8191, 13'd7, 13'd4097};
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: reset settings, extremes of key and amount
      add_req(scs_pkg::OP_INSERT, 64'h0, 64'h7fff_ffff_ffff_ffff);
      add_req(scs_pkg::OP_INSERT, 64'h0, 64'h1);
      add_req(scs_pkg::OP_ESTIMATE, 64'h0, 64'h0);
      add_req(scs_pkg::OP_INSERT, '1, 64'h8000_0000_0000_0000);
      add_req(scs_pkg::OP_INSERT, '1, 64'h8000_0000_0000_0000);
      add_req(scs_pkg::OP_ESTIMATE, '1, '1);
      add_req(scs_pkg::OP_INSERT, 64'h5555_5555_5555_5555, '1);
      add_req(scs_pkg::OP_INSERT, 64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);
      add_req(scs_pkg::OP_ESTIMATE, 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
      add_req(scs_pkg::OP_ESTIMATE, 64'haaaa_aaaa_aaaa_aaaa, 64'h0);
      drain();

      // receiver holds off while requests keep coming
      random_phase(6, 3);
      -> hold_go;
      drain();

      for (int p = 0; p < 6; p++) begin
         write_reg(scs_pkg::REG_ROWS, 13'(row_set[p]));
         write_reg(scs_pkg::REG_WIDTH, width_set[p]);
         add_req(scs_pkg::OP_INSERT, '1, 64'h7fff_ffff_ffff_ffff);
         add_req(scs_pkg::OP_ESTIMATE, '1, 64'h0);
         random_phase(130, (p % 2) ? 4 : 12);
         drain();   // sender pauses until all responses are in
      end
      write_reg(scs_pkg::REG_ROWS, 13'd8);
      write_reg(scs_pkg::REG_WIDTH, 13'd3);
      quiet = 1;
      random_phase(100, 5);
      drain();
      if (errors == 0) begin
         $display("PASS signed_count_sketch");
      end else begin
         $display("FAIL signed_count_sketch");
      end
      $finish;
   end

   initial begin
      #6_000_000;
      $display("FAIL signed_count_sketch");
      $finish;
   end
endmodule
